FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the keyboard queue transmitter
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// implication checked on every rising clock edge outside reset
`define KPQ_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);
// condition that must never hold outside reset
`define KPQ_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);
`else
`define KPQ_ASSERT(label, clk, rst_n, prop, msg)
`define KPQ_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

FILE: design/kpq_pkg.sv
// ----------------------------------------------------------------------------
// kpq_pkg
// widths, timing constants and codes of the keyboard queue transmitter
// ----------------------------------------------------------------------------
package kpq_pkg;

	// byte ring, power of two, one slot always kept empty
	localparam int QUEUE_DEPTH    = 16;
	localparam int QIDX_W         = $clog2(QUEUE_DEPTH);

	// link timing in 1 us ticks
	localparam int LEAD_TICKS     = 10;
	localparam int START_TICKS    = 15;
	localparam int BIT_TICKS      = 15;
	localparam int LONG_BIT_TICKS = 30;
	localparam int STOP_TICKS     = 15;

	localparam int CMD_W   = 2;
	localparam int BYTE_W  = 8;
	localparam int CODE_W  = 7;
	localparam int CFG_IDX_W = 3;
	localparam int DROP_W  = 3;
	localparam int FILL_W  = 4;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK    = 2'd0,
		CMD_KEY     = 2'd1,
		CMD_SOFTPWR = 2'd2,
		CMD_RESTART = 2'd3
	} command_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LAYOUT    = 3'd0,
		REG_INIT      = 3'd1,
		REG_SOFTPWR   = 3'd2,
		REG_APPLE     = 3'd3,
		REG_LOPTION   = 3'd4,
		REG_ROPTION   = 3'd5,
		REG_SHIFT     = 3'd6,
		REG_SYNCLIMIT = 3'd7
	} cfg_reg_t;

	localparam logic [BYTE_W-1:0] SYNC_LIMIT_RST = 8'd128;
	localparam logic [BYTE_W-1:0] TICKS_MAX      = 8'hFF;

endpackage

FILE: design/kpq_if.sv
// ----------------------------------------------------------------------------
// kpq interfaces
// valid/ready channels for key items, results and register writes
// ----------------------------------------------------------------------------
interface kpq_in_if;
	import kpq_pkg::*;
	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    command;
	logic                line_level;
	logic [BYTE_W-1:0]   key_code;
	logic                with_apple;
	logic                with_left_option;
	logic                with_right_option;
	logic                with_shift;

	modport source (output valid, command, line_level, key_code, with_apple,
		with_left_option, with_right_option, with_shift, input ready);
	modport sink (input valid, command, line_level, key_code, with_apple,
		with_left_option, with_right_option, with_shift, output ready);
endinterface

interface kpq_out_if;
	import kpq_pkg::*;
	logic                valid;
	logic                ready;
	logic                line_drive_enable;
	logic                line_drive_level;
	logic [DROP_W-1:0]   dropped_count;
	logic [FILL_W-1:0]   queue_fill;

	modport source (output valid, line_drive_enable, line_drive_level,
		dropped_count, queue_fill, input ready);
	modport sink (input valid, line_drive_enable, line_drive_level,
		dropped_count, queue_fill, output ready);
endinterface

interface kpq_cfg_if;
	import kpq_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [BYTE_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: design/keyboard_packet_queue_transmitter_top.sv
// tick, soft power and restart beats give their result in the cycle after accept;
// key event beats walk five queue write slots and register their result on the last one
// one beat per cycle for ticks that do not pop or reload, while the result side keeps up;
// a pop holds off the next beat through ST_POP, a reload through ST_RELOAD, a key event
// through the ST_KEY walk, set by the single write port and registered read of the queue memory
// reset: arst_n clears indexes, link phase, registers and output valid; queue memory is not cleared
`include "assert_macros.svh"

// ----------------------------------------------------------------------------
// keyboard_packet_queue_transmitter_top
// key byte ring in a synchronous memory plus the one-wire link sender
// ----------------------------------------------------------------------------
module keyboard_packet_queue_transmitter_top (
	input  logic        clk,
	input  logic        arst_n,
	kpq_in_if.sink      item,
	kpq_out_if.source   result,
	kpq_cfg_if.sink     cfg
);
	import kpq_pkg::*;

	// link phases, bit phases follow the wire order 4,5,6,7,0,1,2,3
	typedef enum logic [3:0] {
		PH_WAIT  = 4'd0,
		PH_SYNC  = 4'd1,
		PH_LEAD  = 4'd2,
		PH_START = 4'd3,
		PH_BIT0  = 4'd4,
		PH_BIT1  = 4'd5,
		PH_BIT2  = 4'd6,
		PH_BIT3  = 4'd7,
		PH_BIT4  = 4'd8,
		PH_BIT5  = 4'd9,
		PH_BIT6  = 4'd10,
		PH_BIT7  = 4'd11,
		PH_STOP  = 4'd12
	} link_phase_t;

	// sequencer around the queue memory
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_POP,
		ST_RELOAD,
		ST_KEY
	} seq_state_t;

	localparam int KEY_SLOTS = 5;
	localparam int STEP_W    = $clog2(KEY_SLOTS);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(KEY_SLOTS - 1);

	// configuration registers
	logic [BYTE_W-1:0] layout_code_q, init_code_q, soft_power_code_q, sync_limit_q;
	logic [CODE_W-1:0] apple_code_q, left_option_code_q, right_option_code_q, shift_code_q;

	// queue memory and indexes
	logic [BYTE_W-1:0] queue_mem [QUEUE_DEPTH];
	logic [BYTE_W-1:0] mem_rdata_s1;
	logic              mem_we;
	logic [QIDX_W-1:0] mem_waddr;
	logic [BYTE_W-1:0] mem_wdata;
	logic [QIDX_W-1:0] rd_idx_q, wr_idx_q;

	// link state
	link_phase_t       phase_q;
	logic [BYTE_W-1:0] ticks_q;
	logic [BYTE_W-1:0] send_byte_q;

	// sequencer state
	seq_state_t        state_q;
	logic [BYTE_W-1:0] reload_second_q;
	logic [BYTE_W-1:0] key_byte_q [KEY_SLOTS];
	logic [KEY_SLOTS-1:0] key_en_q;
	logic [STEP_W-1:0] step_q;
	logic [DROP_W-1:0] drop_q;

	// output register
	logic              out_valid_q;
	logic              out_en_q, out_lv_q;
	logic [DROP_W-1:0] out_drop_q;
	logic [FILL_W-1:0] out_fill_q;

	// handshakes
	logic     in_acc;
	command_t cmd;

	// next link state for an accepted beat
	link_phase_t       ph_n;
	logic [BYTE_W-1:0] ticks_n;
	logic              tick_reload, tick_pop;
	logic              any_reload;
	logic [BYTE_W-1:0] reload_second;
	logic [QIDX_W-1:0] rd_after, wr_after;
	logic [BYTE_W:0]   ticks_inc;
	logic [BYTE_W-1:0] cur_len;

	// key walk step
	logic [QIDX_W-1:0] key_nxt;
	logic              key_put, key_full;
	logic [QIDX_W-1:0] key_wr_n;
	logic [DROP_W-1:0] key_drop_n;

	// drive from a phase and the byte on the wire
	logic              drv_en_acc, drv_lv_acc, drv_en_cur, drv_lv_cur;

	function automatic logic [BYTE_W-1:0] phase_len(link_phase_t ph);
		logic [BYTE_W-1:0] len;
		unique case (ph)
			PH_LEAD:  len = BYTE_W'(LEAD_TICKS);
			PH_START: len = BYTE_W'(START_TICKS);
			PH_STOP:  len = BYTE_W'(STOP_TICKS);
			PH_BIT3:  len = BYTE_W'(LONG_BIT_TICKS);
			default:  len = BYTE_W'(BIT_TICKS);
		endcase
		return len;
	endfunction

	// a one bit is pulled low, start bit is always low
	function automatic logic [1:0] drive_of(link_phase_t ph, logic [BYTE_W-1:0] b);
		logic [2:0] slot;
		logic [2:0] bsel;
		logic [1:0] d;
		slot = 3'(ph - PH_BIT0);
		bsel = {~slot[2], slot[1:0]};
		if (ph == PH_START) begin
			d = 2'b10;
		end else if (ph >= PH_BIT0 && ph <= PH_BIT7) begin
			d = {1'b1, ~b[bsel]};
		end else begin
			d = 2'b00;
		end
		return d;
	endfunction

	assign cmd    = command_t'(item.command);
	// a new beat is taken only when the sequencer is idle and the output register is empty or its result is taken
	assign item.ready = (state_q == ST_IDLE) && (!out_valid_q || result.ready);
	assign in_acc = item.valid && item.ready;
	assign cfg.ready = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layout_code_q       <= '0;
			init_code_q         <= '0;
			soft_power_code_q   <= '0;
			apple_code_q        <= '0;
			left_option_code_q  <= '0;
			right_option_code_q <= '0;
			shift_code_q        <= '0;
			sync_limit_q        <= SYNC_LIMIT_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_LAYOUT:    layout_code_q       <= cfg.data;
				REG_INIT:      init_code_q         <= cfg.data;
				REG_SOFTPWR:   soft_power_code_q   <= cfg.data;
				REG_APPLE:     apple_code_q        <= cfg.data[CODE_W-1:0];
				REG_LOPTION:   left_option_code_q  <= cfg.data[CODE_W-1:0];
				REG_ROPTION:   right_option_code_q <= cfg.data[CODE_W-1:0];
				REG_SHIFT:     shift_code_q        <= cfg.data[CODE_W-1:0];
				REG_SYNCLIMIT: sync_limit_q        <= cfg.data;
			endcase
		end
	end

	// link step for a tick beat, restart forces wait
	always_comb begin
		ph_n        = phase_q;
		ticks_n     = ticks_q;
		tick_reload = 1'b0;
		tick_pop    = 1'b0;
		cur_len     = phase_len(phase_q);
		ticks_inc   = {1'b0, ticks_q} + 9'd1;
		if (cmd == CMD_TICK) begin
			unique case (phase_q)
				PH_WAIT: begin
					if (!item.line_level) begin
						ph_n    = PH_SYNC;
						ticks_n = '0;
					end
				end
				PH_SYNC: begin
					if (!item.line_level) begin
						// low time saturates
						if (ticks_q != TICKS_MAX) begin
							ticks_n = ticks_inc[BYTE_W-1:0];
						end
					end else if (ticks_q >= sync_limit_q) begin
						// long pulse: host asks for a fresh start
						tick_reload = 1'b1;
						ph_n        = PH_WAIT;
						ticks_n     = '0;
					end else if (rd_idx_q == wr_idx_q) begin
						ph_n    = PH_WAIT;
						ticks_n = '0;
					end else begin
						tick_pop = 1'b1;
						ph_n     = PH_LEAD;
						ticks_n  = '0;
					end
				end
				PH_LEAD, PH_START, PH_BIT0, PH_BIT1, PH_BIT2, PH_BIT3,
				PH_BIT4, PH_BIT5, PH_BIT6, PH_BIT7, PH_STOP: begin
					if (ticks_inc >= {1'b0, cur_len}) begin
						ticks_n = '0;
						ph_n    = (phase_q == PH_STOP) ? PH_WAIT
						                               : link_phase_t'(phase_q + 4'd1);
					end else begin
						ticks_n = ticks_inc[BYTE_W-1:0];
					end
				end
				default: begin
					ph_n    = PH_WAIT;
					ticks_n = '0;
				end
			endcase
		end else if (cmd == CMD_RESTART) begin
			ph_n    = PH_WAIT;
			ticks_n = '0;
		end
	end

	assign any_reload    = tick_reload || cmd == CMD_SOFTPWR || cmd == CMD_RESTART;
	assign reload_second = (cmd == CMD_SOFTPWR) ? soft_power_code_q : layout_code_q;

	always_comb begin
		rd_after = rd_idx_q;
		wr_after = wr_idx_q;
		if (any_reload) begin
			rd_after = '0;
			wr_after = QIDX_W'(2);
		end else if (tick_pop) begin
			rd_after = rd_idx_q + 1'b1;
		end
	end

	// at most one put per step of the key walk, a full ring drops the byte
	assign key_put    = key_en_q[step_q];
	assign key_nxt    = wr_idx_q + 1'b1;
	assign key_full   = key_nxt == rd_idx_q;
	assign key_wr_n   = (key_put && !key_full) ? key_nxt : wr_idx_q;
	assign key_drop_n = drop_q + DROP_W'(key_put && key_full);

	// single write port
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = wr_idx_q;
		mem_wdata = key_byte_q[step_q];
		priority if (in_acc && any_reload) begin
			mem_we    = 1'b1;
			mem_waddr = '0;
			mem_wdata = init_code_q;
		end else if (state_q == ST_RELOAD) begin
			mem_we    = 1'b1;
			mem_waddr = QIDX_W'(1);
			mem_wdata = reload_second_q;
		end else if (state_q == ST_KEY) begin
			mem_we    = key_put && !key_full;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			queue_mem[mem_waddr] <= mem_wdata;
		end
		// head entry is read every cycle, a pop uses the beat after accept
		mem_rdata_s1 <= queue_mem[rd_idx_q];
	end

	assign {drv_en_acc, drv_lv_acc} = drive_of(ph_n, send_byte_q);
	assign {drv_en_cur, drv_lv_cur} = drive_of(phase_q, send_byte_q);

	// sequencer, link state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_idx_q    <= '0;
			wr_idx_q    <= '0;
			phase_q     <= PH_WAIT;
			ticks_q     <= '0;
			send_byte_q <= '0;
			key_en_q    <= '0;
			step_q      <= '0;
			drop_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						phase_q  <= ph_n;
						ticks_q  <= ticks_n;
						rd_idx_q <= rd_after;
						wr_idx_q <= wr_after;
						reload_second_q <= reload_second;
						if (cmd == CMD_KEY) begin
							step_q <= '0;
							drop_q <= '0;
							if (item.key_code[BYTE_W-1]) begin
								// press: modifiers go down ahead of the key
								key_byte_q[0] <= {1'b1, apple_code_q};
								key_byte_q[1] <= {1'b1, left_option_code_q};
								key_byte_q[2] <= {1'b1, right_option_code_q};
								key_byte_q[3] <= {1'b1, shift_code_q};
								key_byte_q[4] <= item.key_code;
								key_en_q <= {1'b1, item.with_shift, item.with_right_option,
									item.with_left_option, item.with_apple};
							end else begin
								// release: key first, modifiers up in reverse
								key_byte_q[0] <= item.key_code;
								key_byte_q[1] <= {1'b0, shift_code_q};
								key_byte_q[2] <= {1'b0, right_option_code_q};
								key_byte_q[3] <= {1'b0, left_option_code_q};
								key_byte_q[4] <= {1'b0, apple_code_q};
								key_en_q <= {item.with_apple, item.with_left_option,
									item.with_right_option, item.with_shift, 1'b1};
							end
							state_q <= ST_KEY;
						end else begin
							out_valid_q <= 1'b1;
							out_en_q    <= drv_en_acc;
							out_lv_q    <= drv_lv_acc;
							out_drop_q  <= '0;
							out_fill_q  <= FILL_W'(wr_after - rd_after);
							priority if (any_reload) begin
								state_q <= ST_RELOAD;
							end else if (tick_pop) begin
								state_q <= ST_POP;
							end else begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				ST_POP: begin
					send_byte_q <= mem_rdata_s1;
					state_q     <= ST_IDLE;
				end
				ST_RELOAD: begin
					state_q <= ST_IDLE;
				end
				ST_KEY: begin
					wr_idx_q <= key_wr_n;
					drop_q   <= key_drop_n;
					step_q   <= step_q + 1'b1;
					if (step_q == LAST_STEP) begin
						// output register was freed before this beat was taken
						out_valid_q <= 1'b1;
						out_en_q    <= drv_en_cur;
						out_lv_q    <= drv_lv_cur;
						out_drop_q  <= key_drop_n;
						out_fill_q  <= FILL_W'(key_wr_n - rd_idx_q);
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result.valid             = out_valid_q;
	assign result.line_drive_enable = out_en_q;
	assign result.line_drive_level  = out_lv_q;
	assign result.dropped_count     = out_drop_q;
	assign result.queue_fill        = out_fill_q;

	// checks
	`KPQ_ASSERT(a_reload_idx, clk, arst_n,
		(state_q == ST_RELOAD) |-> (rd_idx_q == '0 && wr_idx_q == QIDX_W'(2)),
		"reload did not reset the ring indexes")
	`KPQ_ASSERT(a_send_after_pop, clk, arst_n,
		!$stable(send_byte_q) |-> $past(state_q == ST_POP),
		"sent byte changed outside a pop")
	`KPQ_ASSERT(a_key_rd_stable, clk, arst_n,
		(state_q == ST_KEY && $past(state_q == ST_KEY)) |-> $stable(rd_idx_q),
		"read index moved during a key walk")
	`KPQ_ASSERT(a_out_source, clk, arst_n,
		$rose(out_valid_q) |-> $past(in_acc || (state_q == ST_KEY && step_q == LAST_STEP)),
		"result raised without an item to report")
	`KPQ_NEVER(a_no_drive_idle, clk, arst_n,
		out_valid_q && out_lv_q && !out_en_q,
		"level driven while line released")

endmodule

FILE: test/keyboard_packet_queue_transmitter_top_tb.sv
// ----------------------------------------------------------------------------
// keyboard_packet_queue_transmitter_top_tb
// Sends key events, soft power and restart commands, and line sample ticks to
// the keyboard queue transmitter. Register settings change between phases.
// Each status beat is checked against a typed opening row or a cycle-free model
// of the byte ring and the one-wire sender. Both channels stall at random.
// ----------------------------------------------------------------------------
module keyboard_packet_queue_transmitter_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import kpq_pkg::*;

	localparam int GAP_MAX = 18;
	localparam int PHASE_ITEMS = 270;
	localparam int OPENING_ROWS = 20;
	localparam int SETTLE_CYCLES = 20;
	localparam int unsigned CYCLE_LIMIT = 1000000;

	// sender phases
	localparam logic [3:0] PH_WAIT      = 4'd0;
	localparam logic [3:0] PH_SYNC      = 4'd1;
	localparam logic [3:0] PH_LEAD      = 4'd2;
	localparam logic [3:0] PH_START     = 4'd3;
	localparam logic [3:0] PH_BIT_FIRST = 4'd4;
	localparam logic [3:0] PH_BIT_LONG  = 4'd7;
	localparam logic [3:0] PH_BIT_LAST  = 4'd11;
	localparam logic [3:0] PH_STOP      = 4'd12;

	// one input beat, modifier flags in the order apple, left, right, shift
	typedef struct packed {
		command_t          command;
		logic              line_level;
		logic [BYTE_W-1:0] key_code;
		logic              with_apple;
		logic              with_left_option;
		logic              with_right_option;
		logic              with_shift;
	} key_item_t;

	localparam int ITEM_W = $bits(key_item_t);

	// what the block reports after one beat
	typedef struct packed {
		logic              drive_en;
		logic              drive_lvl;
		logic [DROP_W-1:0] dropped;
		logic [FILL_W-1:0] fill;
	} line_status_t;

	// one row of the opening table; the status is used only where typed is set
	typedef struct packed {
		command_t          cmd;
		logic              lvl;
		logic [BYTE_W-1:0] key;
		logic [3:0]        mods;
		logic              typed;
		logic              en;
		logic              dl;
		logic [DROP_W-1:0] drop;
		logic [FILL_W-1:0] fill;
	} opening_row_t;

	logic clk;
	logic arst_n;

	kpq_in_if  key_if ();
	kpq_out_if status_if ();
	kpq_cfg_if reg_if ();

	keyboard_packet_queue_transmitter_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (key_if),
		.result (status_if),
		.cfg    (reg_if)
	);

	// register copies as the block should hold them
	logic [BYTE_W-1:0] reg_layout = '0;
	logic [BYTE_W-1:0] reg_init = '0;
	logic [BYTE_W-1:0] reg_softpwr = '0;
	logic [CODE_W-1:0] mod_apple = '0;
	logic [CODE_W-1:0] mod_left = '0;
	logic [CODE_W-1:0] mod_right = '0;
	logic [CODE_W-1:0] mod_shift = '0;
	logic [BYTE_W-1:0] reg_sync_limit = SYNC_LIMIT_RST;

	// byte ring and sender state of the model
	logic [BYTE_W-1:0] ring [QUEUE_DEPTH];
	logic [QIDX_W-1:0] ring_rd = '0;
	logic [QIDX_W-1:0] ring_wr = '0;
	logic [3:0]        link_ph = PH_WAIT;
	logic [7:0]        ph_ticks = '0;
	logic [BYTE_W-1:0] tx_byte = '0;

	line_status_t line_status_q [$];

	bit calm = 1'b0;
	int errors = 0;
	int item_count = 0;
	int checked_count = 0;
	int pop_count = 0;
	int reload_count = 0;
	int drop_total = 0;
	int unsigned cycle_count = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// model of the ring
	// ------------------------------------------------------------------

	// one slot stays empty, so a write that would fill the ring is lost
	function automatic int ring_push(logic [BYTE_W-1:0] b);
		logic [QIDX_W-1:0] nxt;
		nxt = ring_wr + 1'b1;
		if (nxt == ring_rd)
			return 1;
		ring[ring_wr] = b;
		ring_wr = nxt;
		return 0;
	endfunction

	function automatic void ring_reload(logic [BYTE_W-1:0] first, logic [BYTE_W-1:0] second);
		ring[0] = first;
		ring[1] = second;
		ring_rd = '0;
		ring_wr = QIDX_W'(2);
	endfunction

	// advance the model by one beat and return the status it should report
	function automatic line_status_t next_line_status(key_item_t it);
		line_status_t st;
		int lost;
		int span;
		logic [2:0] sel;
		lost = 0;
		case (it.command)
			CMD_TICK: begin
				case (link_ph)
					PH_WAIT: begin
						if (!it.line_level) begin
							link_ph = PH_SYNC;
							ph_ticks = '0;
						end
					end
					PH_SYNC: begin
						// low time is counted minus one and saturates
						if (!it.line_level) begin
							if (ph_ticks != TICKS_MAX)
								ph_ticks = ph_ticks + 8'd1;
						end else if (ph_ticks >= reg_sync_limit) begin
							ring_reload(reg_init, reg_layout);
							reload_count++;
							link_ph = PH_WAIT;
							ph_ticks = '0;
						end else if (ring_rd == ring_wr) begin
							link_ph = PH_WAIT;
							ph_ticks = '0;
						end else begin
							tx_byte = ring[ring_rd];
							ring_rd = ring_rd + 1'b1;
							pop_count++;
							link_ph = PH_LEAD;
							ph_ticks = '0;
						end
					end
					default: begin
						if (link_ph >= PH_LEAD && link_ph <= PH_STOP) begin
							case (link_ph)
								PH_LEAD:     span = LEAD_TICKS;
								PH_START:    span = START_TICKS;
								PH_STOP:     span = STOP_TICKS;
								PH_BIT_LONG: span = LONG_BIT_TICKS;
								default:     span = BIT_TICKS;
							endcase
							ph_ticks = ph_ticks + 8'd1;
							if (ph_ticks >= span) begin
								ph_ticks = '0;
								link_ph = (link_ph == PH_STOP) ? PH_WAIT : link_ph + 4'd1;
							end
						end else begin
							link_ph = PH_WAIT;
							ph_ticks = '0;
						end
					end
				endcase
			end
			CMD_KEY: begin
				if (it.key_code[7]) begin
					if (it.with_apple)        lost += ring_push({1'b1, mod_apple});
					if (it.with_left_option)  lost += ring_push({1'b1, mod_left});
					if (it.with_right_option) lost += ring_push({1'b1, mod_right});
					if (it.with_shift)        lost += ring_push({1'b1, mod_shift});
					lost += ring_push(it.key_code);
				end else begin
					lost += ring_push(it.key_code);
					if (it.with_shift)        lost += ring_push({1'b0, mod_shift});
					if (it.with_right_option) lost += ring_push({1'b0, mod_right});
					if (it.with_left_option)  lost += ring_push({1'b0, mod_left});
					if (it.with_apple)        lost += ring_push({1'b0, mod_apple});
				end
			end
			CMD_SOFTPWR: ring_reload(reg_init, reg_softpwr);
			CMD_RESTART: begin
				ring_reload(reg_init, reg_layout);
				link_ph = PH_WAIT;
				ph_ticks = '0;
			end
		endcase
		st = '0;
		if (link_ph == PH_START) begin
			st.drive_en = 1'b1;
		end else if (link_ph >= PH_BIT_FIRST && link_ph <= PH_BIT_LAST) begin
			// high nibble first, a one bit pulls the line low
			sel = 3'(link_ph - PH_BIT_FIRST) ^ 3'd4;
			st.drive_en = 1'b1;
			st.drive_lvl = ~tx_byte[sel];
		end
		st.dropped = DROP_W'(lost);
		st.fill = FILL_W'(QIDX_W'(ring_wr - ring_rd));
		drop_total += lost;
		return st;
	endfunction

	// ------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------

	// one item beat after a random gap; the expectation is queued at accept
	task automatic send_key_item(input key_item_t it, input logic typed, input line_status_t want);
		int gap;
		line_status_t predicted;
		gap = calm ? 0 : $urandom_range(0, GAP_MAX);
		if (gap > 0) begin
			key_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		key_if.valid <= 1'b1;
		key_if.command <= it.command;
		key_if.line_level <= it.line_level;
		key_if.key_code <= it.key_code;
		key_if.with_apple <= it.with_apple;
		key_if.with_left_option <= it.with_left_option;
		key_if.with_right_option <= it.with_right_option;
		key_if.with_shift <= it.with_shift;
		do @(posedge clk); while (!key_if.ready);
		predicted = next_line_status(it);
		line_status_q.push_back(typed ? want : predicted);
		item_count++;
	endtask

	// a line sample beat, the unused fields carry noise
	function automatic key_item_t tick_item(logic lvl);
		key_item_t it;
		it = ITEM_W'($urandom);
		it.command = CMD_TICK;
		it.line_level = lvl;
		return it;
	endfunction

	// stop sending and wait until every expected beat has come back
	task automatic wait_for_status_drain();
		key_if.valid <= 1'b0;
		do @(posedge clk); while (line_status_q.size() != 0);
	endtask

	// valid is left high here so back to back writes need not drop and raise it again
	task automatic write_reg(input cfg_reg_t idx, input logic [BYTE_W-1:0] value);
		reg_if.valid <= 1'b1;
		reg_if.index <= idx;
		reg_if.data <= value;
		do @(posedge clk); while (!reg_if.ready);
		case (idx)
			REG_LAYOUT:    reg_layout = value;
			REG_INIT:      reg_init = value;
			REG_SOFTPWR:   reg_softpwr = value;
			REG_APPLE:     mod_apple = value[CODE_W-1:0];
			REG_LOPTION:   mod_left = value[CODE_W-1:0];
			REG_ROPTION:   mod_right = value[CODE_W-1:0];
			REG_SHIFT:     mod_shift = value[CODE_W-1:0];
			REG_SYNCLIMIT: reg_sync_limit = value;
		endcase
	endtask

	task automatic write_settings(input logic [BYTE_W-1:0] layout, input logic [BYTE_W-1:0] init,
			input logic [BYTE_W-1:0] softpwr, input logic [BYTE_W-1:0] apple,
			input logic [BYTE_W-1:0] lopt, input logic [BYTE_W-1:0] ropt,
			input logic [BYTE_W-1:0] shift, input logic [BYTE_W-1:0] sync_limit);
		write_reg(REG_LAYOUT, layout);
		write_reg(REG_INIT, init);
		write_reg(REG_SOFTPWR, softpwr);
		write_reg(REG_APPLE, apple);
		write_reg(REG_LOPTION, lopt);
		write_reg(REG_ROPTION, ropt);
		write_reg(REG_SHIFT, shift);
		write_reg(REG_SYNCLIMIT, sync_limit);
		reg_if.valid <= 1'b0;
	endtask

	// opening table; the first rows run on an empty ring, then fill it past full,
	// pop during a sync, and hit soft power and restart while a byte is in flight
	function automatic opening_row_t opening_row(int n);
		case (n)
			// idle line, then a short sync with nothing queued
			0:  return '{CMD_TICK, 1'b1, 8'h00, 4'b0000, 1'b1, 1'b0, 1'b0, 3'd0, 4'd0};
			1:  return '{CMD_TICK, 1'b0, 8'h00, 4'b0000, 1'b1, 1'b0, 1'b0, 3'd0, 4'd0};
			2:  return '{CMD_TICK, 1'b0, 8'hFF, 4'b1111, 1'b1, 1'b0, 1'b0, 3'd0, 4'd0};
			3:  return '{CMD_TICK, 1'b1, 8'h00, 4'b0000, 1'b1, 1'b0, 1'b0, 3'd0, 4'd0};
			// fill the ring, the last key events lose some or all writes
			4:  return '{CMD_KEY,  1'b0, 8'h00, 4'b0000, 1'b1, 1'b0, 1'b0, 3'd0, 4'd1};
			5:  return '{CMD_KEY,  1'b1, 8'hFF, 4'b1111, 1'b1, 1'b0, 1'b0, 3'd0, 4'd6};
			6:  return '{CMD_KEY,  1'b0, 8'h7F, 4'b1111, 1'b1, 1'b0, 1'b0, 3'd0, 4'd11};
			7:  return '{CMD_KEY,  1'b1, 8'h80, 4'b1111, 1'b1, 1'b0, 1'b0, 3'd1, 4'd15};
			8:  return '{CMD_KEY,  1'b0, 8'h55, 4'b1111, 1'b1, 1'b0, 1'b0, 3'd5, 4'd15};
			9:  return '{CMD_KEY,  1'b0, 8'hAA, 4'b0001, 1'b1, 1'b0, 1'b0, 3'd2, 4'd15};
			// short sync pops one byte, a low while sending is ignored
			10: return '{CMD_TICK, 1'b0, 8'h00, 4'b0000, 1'b1, 1'b0, 1'b0, 3'd0, 4'd15};
			11: return '{CMD_TICK, 1'b1, 8'h00, 4'b0000, 1'b1, 1'b0, 1'b0, 3'd0, 4'd14};
			12: return '{CMD_TICK, 1'b0, 8'h00, 4'b0000, 1'b1, 1'b0, 1'b0, 3'd0, 4'd14};
			13: return '{CMD_SOFTPWR, 1'b0, 8'h00, 4'b0000, 1'b1, 1'b0, 1'b0, 3'd0, 4'd2};
			14: return '{CMD_KEY,  1'b0, 8'h01, 4'b1000, 1'b1, 1'b0, 1'b0, 3'd0, 4'd4};
			15: return '{CMD_RESTART, 1'b1, 8'h00, 4'b0000, 1'b1, 1'b0, 1'b0, 3'd0, 4'd2};
			16: return '{CMD_TICK, 1'b0, 8'h00, 4'b0000, 1'b1, 1'b0, 1'b0, 3'd0, 4'd2};
			17: return '{CMD_TICK, 1'b1, 8'h00, 4'b0000, 1'b1, 1'b0, 1'b0, 3'd0, 4'd1};
			// mixed modifiers while the byte goes out, left to the model
			18: return '{CMD_KEY,  1'b0, 8'hC3, 4'b1010, 1'b0, 1'b0, 1'b0, 3'd0, 4'd0};
			default: return '{CMD_KEY, 1'b1, 8'h3C, 4'b0101, 1'b0, 1'b0, 1'b0, 3'd0, 4'd0};
		endcase
	endfunction

	// random traffic, mostly sync pulses followed by a high stretch of random length
	// that at its longest lets a popped byte go out whole
	task automatic run_random(input int budget);
		int start;
		int lows;
		int highs;
		int pick;
		key_item_t it;
		start = item_count;
		while (item_count - start < budget) begin
			if ($urandom_range(0, 79) == 0)
				calm = !calm;
			if ($urandom_range(0, 89) == 0)
				wait_for_status_drain();
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				if ($urandom_range(0, 7) == 0) begin
					// long pulse: just past the limit, or past the saturation point
					if ($urandom_range(0, 3) == 0)
						lows = 256 + $urandom_range(0, 20);
					else
						lows = reg_sync_limit + 1 + ($urandom_range(0, 1) ? 0 : $urandom_range(1, 30));
				end else if ($urandom_range(0, 11) == 0) begin
					// longest pulse that still pops
					lows = reg_sync_limit;
				end else begin
					lows = $urandom_range(1, reg_sync_limit < 6 ? reg_sync_limit : 6);
				end
				highs = $urandom_range(1, 190);
				repeat (lows) send_key_item(tick_item(1'b0), 1'b0, '0);
				send_key_item(tick_item(1'b1), 1'b0, '0);
				repeat (highs - 1)
					send_key_item(tick_item($urandom_range(0, 7) != 0), 1'b0, '0);
			end else if (pick < 80) begin
				it = ITEM_W'($urandom);
				it.command = CMD_KEY;
				send_key_item(it, 1'b0, '0);
			end else if (pick < 85) begin
				it = ITEM_W'($urandom);
				it.command = CMD_SOFTPWR;
				send_key_item(it, 1'b0, '0);
			end else if (pick < 90) begin
				it = ITEM_W'($urandom);
				it.command = CMD_RESTART;
				send_key_item(it, 1'b0, '0);
			end else begin
				// any command with any fields
				it = ITEM_W'($urandom);
				send_key_item(it, 1'b0, '0);
			end
		end
	endtask

	// ------------------------------------------------------------------
	// status side: random stalls on ready, every beat checked in order
	// ------------------------------------------------------------------

	initial begin : status_sink
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			stall = calm ? 0 : $urandom_range(0, GAP_MAX);
			if (stall > 0) begin
				status_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			status_if.ready <= 1'b1;
			do @(posedge clk); while (!status_if.valid);
		end
	end

	task automatic flag_status_mismatch(input string field, input int want, input int got);
		errors++;
		$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
	endtask

	always @(posedge clk) begin : status_check
		line_status_t want;
		if (arst_n && status_if.valid && status_if.ready) begin
			checked_count++;
			if (line_status_q.size() == 0) begin
				errors++;
				$display("%0t: status beat with nothing expected: en %0b lvl %0b dropped %0d fill %0d",
					$time, status_if.line_drive_enable, status_if.line_drive_level,
					status_if.dropped_count, status_if.queue_fill);
			end else begin
				want = line_status_q.pop_front();
				if (status_if.line_drive_enable !== want.drive_en)
					flag_status_mismatch("line_drive_enable", want.drive_en,
						status_if.line_drive_enable);
				if (status_if.line_drive_level !== want.drive_lvl)
					flag_status_mismatch("line_drive_level", want.drive_lvl,
						status_if.line_drive_level);
				if (status_if.dropped_count !== want.dropped)
					flag_status_mismatch("dropped_count", want.dropped, status_if.dropped_count);
				if (status_if.queue_fill !== want.fill)
					flag_status_mismatch("queue_fill", want.fill, status_if.queue_fill);
			end
		end
	end

	// hard stop if the handshakes hang
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("keyboard_packet_queue_transmitter_top test failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------

	initial begin : main_flow
		opening_row_t row;
		key_item_t it;

		// every input known from time zero
		arst_n <= 1'b0;
		key_if.valid <= 1'b0;
		key_if.command <= CMD_TICK;
		key_if.line_level <= 1'b1;
		key_if.key_code <= '0;
		key_if.with_apple <= 1'b0;
		key_if.with_left_option <= 1'b0;
		key_if.with_right_option <= 1'b0;
		key_if.with_shift <= 1'b0;
		status_if.ready <= 1'b0;
		reg_if.valid <= 1'b0;
		reg_if.index <= REG_LAYOUT;
		reg_if.data <= '0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first setting keeps the reset sync limit so the opening rows hold
		write_settings(8'h00, 8'hFF, 8'h80, 8'h37, 8'h3A, 8'h7F, 8'h00, SYNC_LIMIT_RST);
		for (int n = 0; n < OPENING_ROWS; n++) begin
			row = opening_row(n);
			it = {row.cmd, row.lvl, row.key, row.mods};
			send_key_item(it, row.typed, {row.en, row.dl, row.drop, row.fill});
		end
		run_random(PHASE_ITEMS);

		// sync limit of one, code registers written with bit 7 set and clear
		wait_for_status_drain();
		write_settings(8'hFF, 8'h00, 8'h7F, 8'hFF, 8'h80, 8'h00, 8'h7F, 8'd1);
		run_random(PHASE_ITEMS);

		// longest sync limit, where a reload needs the saturated count
		wait_for_status_drain();
		write_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom), 8'($urandom), 8'($urandom), TICKS_MAX);
		run_random(PHASE_ITEMS);

		wait_for_status_drain();
		write_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom_range(2, 254)));
		run_random(PHASE_ITEMS);

		// let every status beat come back, then watch for strays
		wait_for_status_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (line_status_q.size() != 0) begin
			errors++;
			$display("%0t: %0d status beats never arrived", $time, line_status_q.size());
		end

		$display("sent %0d item beats under four register settings, checked %0d status beats",
			item_count, checked_count);
		$display("link popped %0d bytes, reloaded on %0d long syncs, lost %0d ring writes",
			pop_count, reload_count, drop_total);
		if (errors == 0) begin
			$display("keyboard_packet_queue_transmitter_top test passed");
		end else begin
			$display("keyboard_packet_queue_transmitter_top test failed");
		end
		$finish;
	end

endmodule
